// File: rtl/fscs_pkg.sv
package fscs_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 128;

   localparam int unsigned KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_NEXT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BUSY = 2'd3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_CLUSTER_BEGIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FAT_BEGIN     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CLUSTER_SHIFT = 2'd2;

   localparam logic [31:0] END_MARK      = 32'hFFFF_FFFF;
   localparam logic [31:0] FIRST_CLUSTER = 32'd2;

   localparam logic MODE_ADVANCE = 1'b0;
   localparam logic MODE_FILL    = 1'b1;

endpackage

// File: rtl/fat32_sector_chain_stepper.sv
// Steps a file through its sectors on a FAT32 volume. An advance beat (tuser 0) whose next
// sector stays in the cluster is answered through the result and output registers. A cluster
// step goes through the control sequencer (cluster arithmetic, cache tag check, synchronous
// read of the FAT sector cache, answer) and is answered with the next sector or an end mark
// on a hit and with a FAT read request on a miss. After a read request, feed exactly
// ENTRIES_PER_FAT_SECTOR fill beats (tuser 1, entry in the upper data word); each is written
// into the cache, and the last one sends the pending step back to the tag check. Advances
// sent during a fill are answered busy. One item is in flight at a time; a finished answer
// may wait in the output register while the next beat is taken. ENTRIES_PER_FAT_SECTOR
// must be a power of two.
module fat32_sector_chain_stepper
   import fscs_pkg::*;
#(
   parameter int unsigned ENTRIES_PER_FAT_SECTOR = ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,   // sector [31:0], fat_word [63:32]
   input  logic                   req_tuser,   // mode [0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // sector_out [31:0]
   output logic [KIND_W-1:0]      rsp_tuser,   // kind [1:0]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam int unsigned IDX_W  = $clog2(ENTRIES_PER_FAT_SECTOR);
   localparam int unsigned FSEC_W = 32 - IDX_W;
   localparam logic [IDX_W-1:0] LAST_FILL = IDX_W'(ENTRIES_PER_FAT_SECTOR - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CALC = 3'd1;
   localparam logic [2:0] ST_LOOK = 3'd2;
   localparam logic [2:0] ST_ANS  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [31:0]       cluster_begin_ff;
   logic [31:0]       fat_begin_ff;
   logic [2:0]        shift_ff;
   logic [FSEC_W-1:0] cached_fsec_ff, cached_fsec_in;
   logic              cache_valid_ff, cache_valid_in;
   logic              fill_pending_ff, fill_pending_in;
   logic [IDX_W-1:0]  fill_count_ff, fill_count_in;
   logic [31:0]       cluster_ff, cluster_in;
   logic [31:0]       sector_ff, sector_in;
   logic [KIND_W-1:0] res_kind_ff, res_kind_in;
   logic [31:0]       res_sector_ff, res_sector_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [31:0]       rsp_sector_ff, rsp_sector_in;

   logic              req_beat;
   logic              req_mode;
   logic [31:0]       req_sector;
   logic [31:0]       req_fat_word;
   logic [31:0]       sector_inc;
   logic [6:0]        low_mask;
   logic              in_cluster;
   logic [FSEC_W-1:0] look_fsec;
   logic              look_hit;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [31:0]       ram_rd_data;
   logic              rsp_slot_free;

   assign req_beat     = req_tvalid && req_tready;
   assign req_mode     = req_tuser;
   assign req_sector   = req_tdata[31:0];
   assign req_fat_word = req_tdata[63:32];
   assign req_tready   = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;

   assign sector_inc = req_sector + 32'd1;
   assign low_mask   = (7'd1 << shift_ff) - 7'd1;
   assign in_cluster = ((sector_inc[6:0] & low_mask) != 7'd0);
   assign look_fsec  = cluster_ff[31:IDX_W];
   assign look_hit   = cache_valid_ff && (cached_fsec_ff == look_fsec);
   assign ram_wr_en  = req_beat && (req_mode == MODE_FILL) && fill_pending_ff;
   assign ram_rd_en  = (state_ff == ST_LOOK) && look_hit;
   assign rsp_slot_free = !rsp_valid_ff || rsp_tready;

   fscs_fat_ram #(
      .DEPTH  (ENTRIES_PER_FAT_SECTOR),
      .ADDR_W (IDX_W)
   ) u_fat_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_count_ff),
      .wr_data (req_fat_word),
      .rd_en   (ram_rd_en),
      .rd_addr (cluster_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in        = state_ff;
      cached_fsec_in  = cached_fsec_ff;
      cache_valid_in  = cache_valid_ff;
      fill_pending_in = fill_pending_ff;
      fill_count_in   = fill_count_ff;
      cluster_in      = cluster_ff;
      sector_in       = sector_ff;
      res_kind_in     = res_kind_ff;
      res_sector_in   = res_sector_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_sector_in   = rsp_sector_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_mode == MODE_FILL) begin
                  if (fill_pending_ff) begin
                     if (fill_count_ff == LAST_FILL) begin
                        fill_pending_in = 1'b0;
                        fill_count_in   = '0;
                        cache_valid_in  = 1'b1;
                        state_in        = ST_LOOK;
                     end else begin
                        fill_count_in = fill_count_ff + IDX_W'(1);
                     end
                  end
               end else if (fill_pending_ff) begin
                  res_kind_in   = KIND_BUSY;
                  res_sector_in = '0;
                  state_in      = ST_EMIT;
               end else if (in_cluster) begin
                  res_kind_in   = KIND_NEXT;
                  res_sector_in = sector_inc;
                  state_in      = ST_EMIT;
               end else begin
                  sector_in = req_sector;
                  state_in  = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            cluster_in = ((sector_ff - cluster_begin_ff) >> shift_ff) + FIRST_CLUSTER;
            state_in   = ST_LOOK;
         end
         ST_LOOK: begin
            if (look_hit) begin
               state_in = ST_ANS;
            end else begin
               cache_valid_in  = 1'b0;
               cached_fsec_in  = look_fsec;
               fill_pending_in = 1'b1;
               fill_count_in   = '0;
               res_kind_in     = KIND_READ;
               res_sector_in   = fat_begin_ff + {{IDX_W{1'b0}}, look_fsec};
               state_in        = ST_EMIT;
            end
         end
         ST_ANS: begin
            if (ram_rd_data == END_MARK) begin
               res_kind_in   = KIND_END;
               res_sector_in = '0;
            end else begin
               res_kind_in   = KIND_NEXT;
               res_sector_in = cluster_begin_ff + ((ram_rd_data - FIRST_CLUSTER) << shift_ff);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_sector_in = res_sector_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cluster_begin_ff <= '0;
         fat_begin_ff     <= '0;
         shift_ff         <= '0;
         cached_fsec_ff   <= '0;
         cache_valid_ff   <= 1'b0;
         fill_pending_ff  <= 1'b0;
         fill_count_ff    <= '0;
         cluster_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cached_fsec_ff  <= cached_fsec_in;
         cache_valid_ff  <= cache_valid_in;
         fill_pending_ff <= fill_pending_in;
         fill_count_ff   <= fill_count_in;
         cluster_ff      <= cluster_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CLUSTER_BEGIN: cluster_begin_ff <= csr_data;
               REG_FAT_BEGIN:     fat_begin_ff     <= csr_data;
               REG_CLUSTER_SHIFT: shift_ff         <= csr_data[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sector_ff     <= sector_in;
      res_kind_ff   <= res_kind_in;
      res_sector_ff <= res_sector_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sector_ff <= rsp_sector_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_sector_ff;

`ifndef SYNTHESIS
   a_fill_drops_cache: assert property (@(posedge clock) disable iff (reset)
      fill_pending_ff |-> !cache_valid_ff)
      else $error("cache marked valid while a fill is pending");

   a_write_needs_fill: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> fill_pending_ff && (state_ff == ST_IDLE))
      else $error("cache written outside a fill");

   a_last_fill_hits: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && (fill_count_ff == LAST_FILL))
         |=> cache_valid_ff && !fill_pending_ff && (state_ff == ST_LOOK) && look_hit)
      else $error("completed fill does not hit the cache");

   a_blank_sector: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_kind_ff == KIND_BUSY) || (rsp_kind_ff == KIND_END)))
         |-> (rsp_sector_ff == 32'd0))
      else $error("busy or end answer carries a sector");
`endif

endmodule

// File: rtl/fscs_fat_ram.sv
module fscs_fat_ram
   import fscs_pkg::*;
#(
   parameter int unsigned DEPTH  = ENTRIES_DEFAULT,
   parameter int unsigned ADDR_W = $clog2(ENTRIES_DEFAULT)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
